@@ hdl/assert_macros.svh @@
// Assertion macros shared by the codec RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Boolean that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Temporal property checked at every clock edge out of reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

@@ hdl/ima_pkg.sv @@
// Types, constants and step table for the IMA ADPCM codec.
package ima_pkg;

	localparam int PredW = 16;
	localparam int IdxW  = 7;
	localparam int CodeW = 4;
	localparam int StepW = 15;

	localparam logic [IdxW-1:0] IdxMax = 7'd88;
	localparam logic signed [PredW-1:0] PredMax = 16'sh7FFF;
	localparam logic signed [PredW-1:0] PredMin = 16'sh8000;

	typedef enum logic [1:0] {
		MODE_LOAD   = 2'd0,
		MODE_ENCODE = 2'd1,
		MODE_DECODE = 2'd2,
		MODE_NOP    = 2'd3
	} mode_t;

	typedef struct packed {
		logic signed [PredW-1:0] predictor;
		logic [IdxW-1:0]         index;
	} codec_state_t;

	localparam logic [StepW-1:0] StepRom [0:88] = '{
		15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
		15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
		15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
		15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
		15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
		15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
		15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
		15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
		15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635, 15'd13899,
		15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086,
		15'd29794, 15'd32767
	};

	function automatic logic [StepW-1:0] step_lookup(input logic [IdxW-1:0] idx);
		logic [IdxW-1:0] sel;
		sel = (idx > IdxMax) ? IdxMax : idx;
		return StepRom[sel];
	endfunction

	// Index change from the code magnitude.
	function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
		logic signed [4:0] adj;
		unique case (mag)
			3'd4:    adj = 5'sd2;
			3'd5:    adj = 5'sd4;
			3'd6:    adj = 5'sd6;
			3'd7:    adj = 5'sd8;
			default: adj = -5'sd1;
		endcase
		return adj;
	endfunction

endpackage

@@ hdl/ima_step.sv @@
// Next-state logic for one codec item: load, encode, decode or no-op.
module codec_next_state import ima_pkg::*; (
	input  mode_t              mode,
	input  logic signed [15:0] sample,
	input  logic [3:0]         nibble_in,
	input  logic [6:0]         index_in,
	input  codec_state_t       cur,
	output codec_state_t       nxt,
	output logic [3:0]         code
);

	logic [StepW-1:0]   step;
	logic signed [16:0] delta;
	logic [16:0]        mag0, mag1, mag2;
	logic               b2, b1, b0;
	logic [3:0]         enc_code, app_code;
	logic [16:0]        diff;
	logic signed [17:0] pred_sum;
	logic signed [15:0] pred_app;
	logic signed [7:0]  idx_sum;
	logic [6:0]         idx_app;

	assign step = step_lookup(cur.index);

	// Quantize the difference against step, step/2, step/4.
	always_comb begin
		delta = 17'(sample) - 17'(cur.predictor);
		mag0 = delta[16] ? 17'(-delta) : 17'(delta);
		b2 = mag0 >= 17'(step);
		mag1 = b2 ? mag0 - 17'(step) : mag0;
		b1 = mag1 >= 17'(step >> 1);
		mag2 = b1 ? mag1 - 17'(step >> 1) : mag1;
		b0 = mag2 >= 17'(step >> 2);
		enc_code = {delta[16], b2, b1, b0};
	end

	assign app_code = (mode == MODE_ENCODE) ? enc_code : nibble_in;

	// Reconstruct the difference the code stands for and apply it.
	always_comb begin
		diff = 17'(step >> 3)
			+ (app_code[2] ? 17'(step) : 17'd0)
			+ (app_code[1] ? 17'(step >> 1) : 17'd0)
			+ (app_code[0] ? 17'(step >> 2) : 17'd0);
		pred_sum = app_code[3] ? 18'(cur.predictor) - 18'(signed'({1'b0, diff}))
			: 18'(cur.predictor) + 18'(signed'({1'b0, diff}));
		if (pred_sum > 18'(PredMax))
			pred_app = PredMax;
		else if (pred_sum < 18'(PredMin))
			pred_app = PredMin;
		else
			pred_app = pred_sum[15:0];
		idx_sum = signed'({1'b0, cur.index}) + 8'(index_adjust(app_code[2:0]));
		if (idx_sum < 8'sd0)
			idx_app = '0;
		else if (idx_sum > signed'({1'b0, IdxMax}))
			idx_app = IdxMax;
		else
			idx_app = idx_sum[6:0];
	end

	always_comb begin
		nxt  = cur;
		code = '0;
		unique case (mode)
			MODE_LOAD: begin
				nxt.predictor = sample;
				nxt.index = (index_in > IdxMax) ? IdxMax : index_in;
			end
			MODE_ENCODE: begin
				nxt.predictor = pred_app;
				nxt.index = idx_app;
				code = enc_code;
			end
			MODE_DECODE: begin
				nxt.predictor = pred_app;
				nxt.index = idx_app;
			end
			MODE_NOP: begin
				nxt = cur;
			end
		endcase
	end

endmodule

@@ hdl/ima_adpcm_sample_codec.sv @@
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle while the result is not stalled; the input register and
// the result register decouple the channels, and the predictor/index update is combinational.
// in_stall rises only when the input register holds an item and the result is stalled.
// Reset clears predictor, step index and both valid flags; payload registers keep no reset.
// IMA ADPCM 4-bit codec top level: input register, step logic, result and state registers.
`include "assert_macros.svh"

module ima_adpcm_sample_codec import ima_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic signed [15:0] sample,
	input  logic [3:0]         nibble_in,
	input  logic [6:0]         index_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         code_out,
	output logic signed [15:0] predictor_out,
	output logic [6:0]         index_out
);

	logic               valid_s1;
	mode_t              mode_s1;
	logic signed [15:0] sample_s1;
	logic [3:0]         nibble_s1;
	logic [6:0]         index_s1;
	codec_state_t       state_q, state_nxt;
	logic [3:0]         code_nxt, code_q;
	logic               out_valid_q;
	logic               advance;
	logic               in_accept;

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	codec_next_state u_step (
		.mode      (mode_s1),
		.sample    (sample_s1),
		.nibble_in (nibble_s1),
		.index_in  (index_s1),
		.cur       (state_q),
		.nxt       (state_nxt),
		.code      (code_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_s1   <= mode_t'(mode);
			sample_s1 <= sample;
			nibble_s1 <= nibble_in;
			index_s1  <= index_in;
		end
	end

	// State and result move together, so the output shows the state directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			state_q     <= state_nxt;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			code_q <= code_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign code_out      = code_q;
	assign predictor_out = state_q.predictor;
	assign index_out     = state_q.index;

	`ASSERT_ALWAYS(a_index_range, clk, arst_n, state_q.index <= IdxMax, "step index above 88")
	`ASSERT_PROP(a_accept_fills, clk, arst_n, in_accept |=> valid_s1, "accepted item lost")
	`ASSERT_PROP(a_code_zero, clk, arst_n, advance && mode_s1 != MODE_ENCODE |=> code_out == 4'd0,
		"nonzero code outside encode")
	`ASSERT_PROP(a_state_hold, clk, arst_n, !advance |=> $stable(state_q),
		"state changed without an item")

endmodule
